FILE: src/ipt_pkg.sv
// ----------------------------------------------------------------------------
// IP address text parser package
// Shared payload types, parser state layout, character codes and limits.
// ----------------------------------------------------------------------------
`default_nettype none

package ipt_pkg;

    // Address geometry: eight 16-bit groups make one 128-bit address.
    localparam int GROUP_W = 16;
    localparam int ADDR_W  = 128;
    localparam int QUAD_W  = 32;

    // Character codes the parser reacts to.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;

    // Parser limits.
    localparam logic [3:0]  GROUP_COUNT     = 4'd8;
    localparam logic [3:0]  TAIL_MAX_GROUPS = 4'd6;
    localparam logic [2:0]  QUAD_OCTETS     = 3'd4;
    localparam logic [2:0]  QUAD_POISON     = 3'd7;
    localparam logic [11:0] OCTET_MAX       = 12'd255;
    localparam logic [15:0] GROUP_NEAR_FULL = 16'h0fff;
    localparam logic [3:0]  HEX_ALPHA_BIAS  = 4'd9;

    // Address family select carried with every character.
    localparam logic FAMILY_V4 = 1'b0;
    localparam logic FAMILY_V6 = 1'b1;

    // Position within the IPv6 text.
    typedef enum logic [1:0] {
        PH_START       = 2'd0,
        PH_LEAD_COLON  = 2'd1,
        PH_BODY        = 2'd2,
        PH_AFTER_COLON = 2'd3
    } t_phase;

    // One input character.
    typedef struct packed {
        logic [7:0] char_code;
        logic       address_family;
    } t_char_item;

    // One parse result.
    typedef struct packed {
        logic        parse_ok;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } t_addr_item;

    // Input register towards the parser core.
    typedef struct packed {
        logic       fire;
        t_char_item item;
    } t_parse_req;

    // Dotted-quad sub-parser state.
    typedef struct packed {
        logic [QUAD_W-1:0] bytes;
        logic [2:0]        count;
        logic              digit_seen;
    } t_quad_state;

    // Complete parser state. Groups before the gap sit at fixed slots of
    // head; groups after the gap shift into the low end of tail.
    typedef struct packed {
        logic [ADDR_W-1:0]  head;
        logic [ADDR_W-1:0]  tail;
        logic [3:0]         groups;
        logic               gap_seen;
        logic [GROUP_W-1:0] accum;
        logic               hex_seen;
        t_quad_state        quad;
        logic               tail_mode;
        t_phase             phase;
        logic               error;
    } t_parse_state;

endpackage

`default_nettype wire

FILE: src/ipt_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload item per transfer between a source and a sink.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipt_stream_if #(
    parameter type t_payload = logic
) ();

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

FILE: src/ipt_input_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Captures one character per transfer and hands it to the parser core.
// ----------------------------------------------------------------------------
`default_nettype none

module ipt_input_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire ipt_pkg::t_char_item i_item,
    input  wire logic               i_can_load,
    output logic                    o_ready,
    output ipt_pkg::t_parse_req     o_req
);

    logic                r_valid;
    logic                n_valid;
    ipt_pkg::t_char_item r_item;
    logic                is_term;
    logic                advance;

    // A terminator can only leave when the result register has room.
    assign is_term = (r_item.char_code == ipt_pkg::CH_NUL);
    assign advance = r_valid && (!is_term || i_can_load);
    assign o_ready = !r_valid || advance;

    assign o_req.fire = advance;
    assign o_req.item = r_item;

    // Occupancy of the register.
    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload is loaded on every transfer.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

FILE: src/ipt_parse_core.sv
// ----------------------------------------------------------------------------
// Parser core
// Holds the IPv4/IPv6 parse state, updates it for each character and
// builds the result when the terminator arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module ipt_parse_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ipt_pkg::t_parse_req i_req,
    output logic                     o_load,
    output ipt_pkg::t_addr_item      o_result
);

    ipt_pkg::t_parse_state r_state;
    ipt_pkg::t_parse_state n_state;
    logic                  is_term;

    // State at the start of a string: everything clear, phase at the start.
    function automatic ipt_pkg::t_parse_state idle_state();
        ipt_pkg::t_parse_state s;
        begin
            s          = '0;
            s.phase    = ipt_pkg::PH_START;
            idle_state = s;
        end
    endfunction

    // Place a value at a group slot, slot 0 being the most significant.
    function automatic logic [ipt_pkg::ADDR_W-1:0] place_group(
        input logic [ipt_pkg::QUAD_W-1:0] value,
        input logic [2:0]                 slot,
        input logic                       two_groups
    );
        logic [ipt_pkg::ADDR_W-1:0] top;
        begin
            if (two_groups) begin
                top = {value, {(ipt_pkg::ADDR_W-ipt_pkg::QUAD_W){1'b0}}};
            end else begin
                top = {value[ipt_pkg::GROUP_W-1:0],
                       {(ipt_pkg::ADDR_W-ipt_pkg::GROUP_W){1'b0}}};
            end
            place_group = top >> {slot, 4'b0000};
        end
    endfunction

    // Hex digit decode: bit 4 flags a digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        begin
            if (c >= ipt_pkg::CH_0 && c <= ipt_pkg::CH_9) begin
                hex_digit = {1'b1, c[3:0]};
            end else if ((c >= ipt_pkg::CH_LC_A && c <= ipt_pkg::CH_LC_F) ||
                         (c >= ipt_pkg::CH_UC_A && c <= ipt_pkg::CH_UC_F)) begin
                hex_digit = {1'b1, c[3:0] + ipt_pkg::HEX_ALPHA_BIAS};
            end else begin
                hex_digit = 5'b0_0000;
            end
        end
    endfunction

    // One character into the dotted-quad sub-parser; returns 1 if accepted.
    function automatic logic quad_feed(
        input  ipt_pkg::t_quad_state q,
        input  logic [7:0]           c,
        output ipt_pkg::t_quad_state q_n
    );
        logic [7:0]  cur;
        logic [11:0] next_octet;
        logic        is_digit;
        logic        ok;
        begin
            q_n        = q;
            ok         = 1'b0;
            cur        = q.bytes[7:0];
            is_digit   = (c >= ipt_pkg::CH_0) && (c <= ipt_pkg::CH_9);
            next_octet = {1'b0, cur, 3'b000} + {3'b000, cur, 1'b0} + {8'h00, c[3:0]};
            if (q.count > ipt_pkg::QUAD_OCTETS) begin
                ok = 1'b0;
            end else if (is_digit) begin
                if (q.digit_seen && cur == 8'h00) begin
                    ok = 1'b0;
                end else if (next_octet > ipt_pkg::OCTET_MAX) begin
                    ok = 1'b0;
                end else if (!q.digit_seen && q.count >= ipt_pkg::QUAD_OCTETS) begin
                    ok = 1'b0;
                end else begin
                    ok = 1'b1;
                    if (!q.digit_seen) begin
                        q_n.count      = q.count + 3'd1;
                        q_n.digit_seen = 1'b1;
                    end
                    q_n.bytes[7:0] = next_octet[7:0];
                end
            end else if (c == ipt_pkg::CH_DOT && q.digit_seen) begin
                if (q.count != ipt_pkg::QUAD_OCTETS) begin
                    ok             = 1'b1;
                    q_n.bytes      = {q.bytes[ipt_pkg::QUAD_W-9:0], 8'h00};
                    q_n.digit_seen = 1'b0;
                end
            end
            quad_feed = ok;
        end
    endfunction

    // IPv4 character: only the dotted-quad sub-parser runs.
    function automatic ipt_pkg::t_parse_state v4_step(
        input ipt_pkg::t_parse_state s,
        input logic [7:0]            c
    );
        ipt_pkg::t_parse_state r;
        ipt_pkg::t_quad_state  q_n;
        begin
            r = s;
            if (quad_feed(s.quad, c, q_n)) begin
                r.quad = q_n;
            end else begin
                r.error = 1'b1;
            end
            v4_step = r;
        end
    endfunction

    // IPv6 character: hex groups, the gap, and the dotted tail.
    function automatic ipt_pkg::t_parse_state v6_step(
        input ipt_pkg::t_parse_state s,
        input logic [7:0]            c
    );
        ipt_pkg::t_parse_state r;
        ipt_pkg::t_quad_state  q_n;
        logic                  q_ok;
        logic [4:0]            digit;
        begin
            r     = s;
            q_ok  = quad_feed(s.quad, c, q_n);
            digit = hex_digit(c);
            if (s.tail_mode) begin
                if (q_ok) begin
                    r.quad = q_n;
                end else begin
                    r.error = 1'b1;
                end
            end else if (s.phase == ipt_pkg::PH_START && c == ipt_pkg::CH_COLON) begin
                r.phase = ipt_pkg::PH_LEAD_COLON;
            end else if (s.phase == ipt_pkg::PH_LEAD_COLON && c != ipt_pkg::CH_COLON) begin
                r.error = 1'b1;
            end else begin
                r.phase = ipt_pkg::PH_BODY;
                if (digit[4]) begin
                    if (s.accum > ipt_pkg::GROUP_NEAR_FULL) begin
                        r.error = 1'b1;
                    end else begin
                        r.accum    = {s.accum[ipt_pkg::GROUP_W-5:0], digit[3:0]};
                        r.hex_seen = 1'b1;
                        // The token may still turn out to be a dotted tail.
                        if (q_ok) begin
                            r.quad = q_n;
                        end else begin
                            r.quad.count = ipt_pkg::QUAD_POISON;
                        end
                    end
                end else if (c == ipt_pkg::CH_COLON) begin
                    r.quad = '0;
                    if (!s.hex_seen) begin
                        if (s.gap_seen) begin
                            r.error = 1'b1;
                        end else begin
                            r.gap_seen = 1'b1;
                        end
                    end else if (s.groups >= ipt_pkg::GROUP_COUNT) begin
                        r.error = 1'b1;
                    end else begin
                        if (s.gap_seen) begin
                            r.tail = {s.tail[ipt_pkg::ADDR_W-ipt_pkg::GROUP_W-1:0], s.accum};
                        end else begin
                            r.head = s.head | place_group({16'h0000, s.accum},
                                                          s.groups[2:0], 1'b0);
                        end
                        r.groups   = s.groups + 4'd1;
                        r.accum    = '0;
                        r.hex_seen = 1'b0;
                        r.phase    = ipt_pkg::PH_AFTER_COLON;
                    end
                end else if (c == ipt_pkg::CH_DOT && s.groups <= ipt_pkg::TAIL_MAX_GROUPS &&
                             q_ok) begin
                    r.quad      = q_n;
                    r.tail_mode = 1'b1;
                    r.hex_seen  = 1'b0;
                end else begin
                    r.error = 1'b1;
                end
            end
            v6_step = r;
        end
    endfunction

    // Final checks and gap expansion at the terminator.
    function automatic ipt_pkg::t_addr_item finish(
        input ipt_pkg::t_parse_state s,
        input logic                  family
    );
        logic                       bad;
        logic [3:0]                 groups_f;
        logic [ipt_pkg::ADDR_W-1:0] head_f;
        logic [ipt_pkg::ADDR_W-1:0] tail_f;
        logic [ipt_pkg::ADDR_W-1:0] addr;
        ipt_pkg::t_addr_item        res;
        begin
            bad      = 1'b0;
            groups_f = s.groups;
            head_f   = s.head;
            tail_f   = s.tail;
            addr     = '0;
            if (family == ipt_pkg::FAMILY_V6) begin
                if (s.error || s.phase == ipt_pkg::PH_LEAD_COLON ||
                    s.phase == ipt_pkg::PH_AFTER_COLON) begin
                    bad = 1'b1;
                end
                // Append the open token as the last group or groups.
                if (s.tail_mode) begin
                    if (s.quad.count != ipt_pkg::QUAD_OCTETS ||
                        s.groups > ipt_pkg::TAIL_MAX_GROUPS) begin
                        bad = 1'b1;
                    end
                    groups_f = s.groups + 4'd2;
                    tail_f   = {s.tail[ipt_pkg::ADDR_W-ipt_pkg::QUAD_W-1:0], s.quad.bytes};
                    head_f   = s.head | place_group(s.quad.bytes, s.groups[2:0], 1'b1);
                end else if (s.hex_seen) begin
                    if (s.groups >= ipt_pkg::GROUP_COUNT) begin
                        bad = 1'b1;
                    end
                    groups_f = s.groups + 4'd1;
                    tail_f   = {s.tail[ipt_pkg::ADDR_W-ipt_pkg::GROUP_W-1:0], s.accum};
                    head_f   = s.head | place_group({16'h0000, s.accum}, s.groups[2:0], 1'b0);
                end
                // Groups after the gap already sit at the bottom of tail.
                if (s.gap_seen) begin
                    if (groups_f >= ipt_pkg::GROUP_COUNT) begin
                        bad = 1'b1;
                    end
                    addr = s.head | tail_f;
                end else begin
                    if (groups_f != ipt_pkg::GROUP_COUNT) begin
                        bad = 1'b1;
                    end
                    addr = head_f;
                end
            end else begin
                bad  = s.error || (s.quad.count != ipt_pkg::QUAD_OCTETS);
                addr = {{(ipt_pkg::ADDR_W-ipt_pkg::QUAD_W){1'b0}}, s.quad.bytes};
            end
            if (bad) begin
                addr = '0;
            end
            res.parse_ok  = !bad;
            res.addr_high = addr[ipt_pkg::ADDR_W-1:ipt_pkg::ADDR_W/2];
            res.addr_low  = addr[ipt_pkg::ADDR_W/2-1:0];
            finish = res;
        end
    endfunction

    assign is_term = (i_req.item.char_code == ipt_pkg::CH_NUL);

    // Next parse state: characters update it until an error is flagged, the terminator clears it.
    always_comb begin
        n_state = r_state;
        if (i_req.fire) begin
            if (is_term) begin
                n_state = idle_state();
            end else if (!r_state.error) begin
                if (i_req.item.address_family == ipt_pkg::FAMILY_V6) begin
                    n_state = v6_step(r_state, i_req.item.char_code);
                end else begin
                    n_state = v4_step(r_state, i_req.item.char_code);
                end
            end
        end
    end

    // Result towards the output register.
    always_comb begin
        o_load   = i_req.fire && is_term;
        o_result = finish(r_state, i_req.item.address_family);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= idle_state();
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: src/ipt_result_stage.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one parse result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ipt_result_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire ipt_pkg::t_addr_item i_result,
    input  wire logic                i_ready,
    output logic                     o_valid,
    output ipt_pkg::t_addr_item      o_result,
    output logic                     o_can_load
);

    logic                r_valid;
    logic                n_valid;
    ipt_pkg::t_addr_item r_result;

    // Room for a new result when empty or when the current one leaves now.
    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

FILE: src/ip_address_text_parser_core.sv
// ----------------------------------------------------------------------------
// IP address text parser
// Parses dotted IPv4 or colon-hex IPv6 text, one character per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   i_char carries one character (char_code) and the address family per
//   transfer; a char_code of 0 ends the string. o_addr carries one result
//   per string: parse_ok and the 128-bit address (IPv4 in the low 32 bits).
//   Every character passes an input register, then combinational parser
//   logic that updates the parse state; the terminator's result is written
//   to an output register. A result is offered on o_addr from the edge at
//   which its terminator leaves the input register. Throughput is one
//   character per clock while no terminator waits for the output register.
//   The input register keeps taking characters while a result waits on
//   o_addr; only a second terminator waits in the input register until the
//   output register is free. A synchronous reset empties both registers and
//   returns the parser to the start of a string; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_address_text_parser_core (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    ipt_stream_if.sink   i_char,
    ipt_stream_if.source o_addr
);

    ipt_pkg::t_parse_req req;
    ipt_pkg::t_addr_item result;
    ipt_pkg::t_addr_item out_result;
    logic                in_ready;
    logic                can_load;
    logic                load;
    logic                out_valid;

    // Input register.
    ipt_input_stage u_input (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_char.valid),
        .i_item     (i_char.payload),
        .i_can_load (can_load),
        .o_ready    (in_ready),
        .o_req      (req)
    );

    // Parse state and result logic.
    ipt_parse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .o_load   (load),
        .o_result (result)
    );

    // Output register.
    ipt_result_stage u_result (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_result   (result),
        .i_ready    (o_addr.ready),
        .o_valid    (out_valid),
        .o_result   (out_result),
        .o_can_load (can_load)
    );

    assign i_char.ready   = in_ready;
    assign o_addr.valid   = out_valid;
    assign o_addr.payload = out_result;

endmodule

`default_nettype wire

FILE: src/ipt_checker.sv
// ----------------------------------------------------------------------------
// Parser port checker
// Watches the parser's ports and flags handshake and result violations.
// ----------------------------------------------------------------------------
`default_nettype none

module ipt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_out_ok,
    input wire logic [63:0] i_out_high,
    input wire logic [63:0] i_out_low
);

    // A result offered but not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before its transfer");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_ok) && $stable(i_out_high) && $stable(i_out_low))
        else $error("stalled result changed");

    // A failed parse reports an all-zero address.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ok |-> (i_out_high == 64'h0) && (i_out_low == 64'h0))
        else $error("failed parse with a nonzero address");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

endmodule

bind ip_address_text_parser_core ipt_checker u_ipt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_addr.valid),
    .i_out_ready (o_addr.ready),
    .i_out_ok    (o_addr.payload.parse_ok),
    .i_out_high  (o_addr.payload.addr_high),
    .i_out_low   (o_addr.payload.addr_low)
);

`default_nettype wire
